### sv/quaternion_to_euler_angles_macros.svh
// Assertion macros shared by the quaternion to Euler angle converter.
// Depends on nothing; the files that check their own logic include it.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`define QTE_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define QTE_ASSERT_NOW(label, clk, rst, cond, prop)
`define QTE_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

### sv/qte_pkg.sv
// Types and constants of the quaternion to Euler angle converter.
// Depends on nothing; used by the interfaces, the atan2 pipeline and the top level.
package qte_pkg;

  localparam int Q_W     = 16;  // quaternion component width
  localparam int ANG_W   = 16;  // output binary angle width
  localparam int PROD_W  = 32;  // one Q2.14 product
  localparam int AW      = 36;  // product sums in Q4.28 with headroom
  localparam int PW      = 6;   // bit position within an AW word
  localparam int RW      = 29;  // square root result width
  localparam int VW      = 57;  // square root radicand width
  localparam int ANG_TABLE_LEN = 24;

  localparam logic signed [AW-1:0] ONE_Q28 = 36'sd268435456;
  localparam logic [VW-1:0] ONE_Q56 = 57'h100_0000_0000_0000;
  localparam logic signed [ANG_W-1:0] PITCH_POS = 16'sh4000;
  localparam logic signed [ANG_W-1:0] PITCH_NEG = -16'sh4000;
  localparam logic [31:0] QUARTER_POS = 32'h4000_0000;
  localparam logic [31:0] QUARTER_NEG = 32'hC000_0000;
  localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURNS [ANG_TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [AW-1:0] roll_s;
    logic signed [AW-1:0] roll_c;
    logic signed [AW-1:0] yaw_s;
    logic signed [AW-1:0] yaw_c;
    logic signed [AW-1:0] ps;
    logic                 clamp;
  } ops_t;

  typedef struct packed {
    logic clamp;
    logic neg;
  } pflag_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] roll;
    logic signed [ANG_W-1:0] pitch;
    logic signed [ANG_W-1:0] yaw;
    logic                    clamped;
  } result_t;

  // Position of the highest set bit; zero for a zero word.
  function automatic logic [PW-1:0] msb_pos(input logic [AW-1:0] v);
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < AW; i++) begin
      if (v[i]) p = PW'(i);
    end
    return p;
  endfunction

endpackage

### sv/qte_quat_if.sv
// Request channel carrying one attitude quaternion in Q2.14.
// Depends on qte_pkg.
interface qte_quat_if import qte_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] quat_w;
  logic signed [Q_W-1:0] quat_x;
  logic signed [Q_W-1:0] quat_y;
  logic signed [Q_W-1:0] quat_z;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

### sv/qte_euler_if.sv
// Result channel carrying roll, pitch and yaw binary angles and the clamp flag.
// Depends on qte_pkg.
interface qte_euler_if import qte_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] roll_angle;
  logic signed [ANG_W-1:0] pitch_angle;
  logic signed [ANG_W-1:0] yaw_angle;
  logic                    pitch_clamped;
  modport source(output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                 input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
               output ready);
endinterface

### sv/qte_atan2.sv
// Pipelined atan2 on Q4.28 operands: normalize, pre-rotate, vectoring CORDIC.
// Depends on qte_pkg. Four register stages come before the CORDIC iterations.
module qte_atan2 import qte_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int DATA_BITS     = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    y_in,
  input  logic signed [AW-1:0]    x_in,
  output logic        [ANG_W-1:0] angle
);

  localparam int N   = (CORDIC_STAGES > ANG_TABLE_LEN) ? ANG_TABLE_LEN : CORDIC_STAGES;
  localparam int CW  = DATA_BITS + 2;
  localparam int TGT = DATA_BITS - 3;

  logic        [AW-1:0] ax, ay;
  logic signed [AW-1:0] xa, ya, xb, yb;
  logic        [AW-1:0] ma;
  logic        [PW-1:0] pb;
  logic                 zb, zc;
  logic signed [AW-1:0] xsh, ysh;
  logic signed [CW-1:0] xc, yc;

  logic signed [CW-1:0] cx [N+1];
  logic signed [CW-1:0] cy [N+1];
  logic        [31:0]   ca [N+1];
  logic                 cz [N+1];
  logic        [31:0]   zr;

  assign ax = x_in[AW-1] ? AW'(-x_in) : AW'(x_in);
  assign ay = y_in[AW-1] ? AW'(-y_in) : AW'(y_in);

  always_ff @(posedge clk) begin
    if (en) begin
      xa <= x_in;
      ya <= y_in;
      ma <= (ax > ay) ? ax : ay;
      xb <= xa;
      yb <= ya;
      pb <= msb_pos(ma);
      zb <= (ma == '0);
    end
  end

  // Scale both operands by one shift so the larger magnitude has its top bit at TGT.
  always_comb begin
    if (pb > PW'(TGT)) begin
      xsh = xb >>> (pb - PW'(TGT));
      ysh = yb >>> (pb - PW'(TGT));
    end else begin
      xsh = xb <<< (PW'(TGT) - pb);
      ysh = yb <<< (PW'(TGT) - pb);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xc <= xsh[CW-1:0];
      yc <= ysh[CW-1:0];
      zc <= zb;
      cz[0] <= zc;
      if (xc[CW-1]) begin
        if (!yc[CW-1]) begin
          cx[0] <= yc;
          cy[0] <= -xc;
          ca[0] <= QUARTER_POS;
        end else begin
          cx[0] <= -yc;
          cy[0] <= xc;
          ca[0] <= QUARTER_NEG;
        end
      end else begin
        cx[0] <= xc;
        cy[0] <= yc;
        ca[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        cz[i+1] <= cz[i];
        if (!cy[i][CW-1]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          ca[i+1] <= ca[i] + ATAN_TURNS[i];
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          ca[i+1] <= ca[i] - ATAN_TURNS[i];
        end
      end
    end
  end

  assign zr    = ca[N] + ROUND_HALF;
  assign angle = cz[N] ? '0 : zr[31:16];

endmodule

### sv/quaternion_to_euler_angles.sv
// Top level of the quaternion to ZYX Euler angle converter.
// Depends on qte_pkg, qte_quat_if, qte_euler_if, qte_atan2 and the macros header.
//
//   channel   modport   payload                                         dir
//   quat      sink      quat_w, quat_x, quat_y, quat_z (Q2.14)           in
//   euler     source    roll_angle, pitch_angle, yaw_angle, pitch_clamped out
//
// One request enters per cycle while the skid register is empty; a full one stalls it.
// The pipeline is made of the products and sums (4 stages), the pitch square root
// (one stage per result bit, 29 plus a setup stage) and the CORDIC (stages + 4).
// Reset clears the valid bits only. While the output register holds, one more
// result moves into a skid register, then the whole pipeline stops as a unit.
`include "quaternion_to_euler_angles_macros.svh"
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int DATA_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  qte_quat_if.sink    quat,
  qte_euler_if.source euler
);

  localparam int N      = (CORDIC_STAGES > ANG_TABLE_LEN) ? ANG_TABLE_LEN : CORDIC_STAGES;
  localparam int AT_LAT = N + 4;
  localparam int VLAT   = 4 + (RW + 1) + AT_LAT;

  logic            en;
  logic [VLAT-1:0] vld;

  logic signed [PROD_W-1:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  ops_t                 ops2, ops3, ops4;
  logic signed [AW-1:0] psm;
  logic        [27:0]   psq;
  logic        [55:0]   sq;

  ops_t            sops [RW+1];
  logic [VW-1:0]   rem  [RW+1];
  logic [RW-1:0]   root [RW+1];
  pflag_t          pf   [AT_LAT];

  logic [ANG_W-1:0] roll_a, pitch_a, yaw_a;
  result_t          p_res, ob, sb;
  logic             ob_valid, sb_valid;

  assign en         = !sb_valid;
  assign quat.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[VLAT-2:0], quat.valid};
    end
  end

  assign psm = ops2.ps[AW-1] ? -ops2.ps : ops2.ps;

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= quat.quat_w * quat.quat_x;
      p_yz <= quat.quat_y * quat.quat_z;
      p_xx <= quat.quat_x * quat.quat_x;
      p_yy <= quat.quat_y * quat.quat_y;
      p_wz <= quat.quat_w * quat.quat_z;
      p_xy <= quat.quat_x * quat.quat_y;
      p_zz <= quat.quat_z * quat.quat_z;
      p_wy <= quat.quat_w * quat.quat_y;
      p_zx <= quat.quat_z * quat.quat_x;

      ops2.roll_s <= (AW'(p_wx) + AW'(p_yz)) <<< 1;
      ops2.roll_c <= ONE_Q28 - ((AW'(p_xx) + AW'(p_yy)) <<< 1);
      ops2.yaw_s  <= (AW'(p_wz) + AW'(p_xy)) <<< 1;
      ops2.yaw_c  <= ONE_Q28 - ((AW'(p_yy) + AW'(p_zz)) <<< 1);
      ops2.ps     <= (AW'(p_wy) - AW'(p_zx)) <<< 1;
      ops2.clamp  <= 1'b0;

      // A clamped argument feeds zero to the squarer ahead of the square root; its pitch is replaced later.
      ops3.roll_s <= ops2.roll_s;
      ops3.roll_c <= ops2.roll_c;
      ops3.yaw_s  <= ops2.yaw_s;
      ops3.yaw_c  <= ops2.yaw_c;
      ops3.ps     <= ops2.ps;
      ops3.clamp  <= (psm >= ONE_Q28);
      psq         <= (psm >= ONE_Q28) ? '0 : psm[27:0];

      ops4 <= ops3;
      sq   <= psq * psq;

      sops[0] <= ops4;
      rem[0]  <= ONE_Q56 - VW'(sq);
      root[0] <= '0;
    end
  end

  // Digit-by-digit square root: stage k decides result bit RW-1-k.
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int B = RW - 1 - k;
    logic [VW:0] trial;
    assign trial = ((VW+1)'(root[k]) << (B + 1)) + ((VW+1)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        sops[k+1] <= sops[k];
        if ({1'b0, rem[k]} >= trial) begin
          rem[k+1]  <= VW'({1'b0, rem[k]} - trial);
          root[k+1] <= root[k] | (RW'(1) << B);
        end else begin
          rem[k+1]  <= rem[k];
          root[k+1] <= root[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pf[0].clamp <= sops[RW].clamp;
      pf[0].neg   <= sops[RW].ps[AW-1];
      for (int j = 1; j < AT_LAT; j++) begin
        pf[j] <= pf[j-1];
      end
    end
  end

  qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .DATA_BITS(DATA_BITS)) u_roll (
    .clk  (clk),
    .en   (en),
    .y_in (sops[RW].roll_s),
    .x_in (sops[RW].roll_c),
    .angle(roll_a)
  );

  qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .DATA_BITS(DATA_BITS)) u_pitch (
    .clk  (clk),
    .en   (en),
    .y_in (sops[RW].ps),
    .x_in (signed'(AW'(root[RW]))),
    .angle(pitch_a)
  );

  qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .DATA_BITS(DATA_BITS)) u_yaw (
    .clk  (clk),
    .en   (en),
    .y_in (sops[RW].yaw_s),
    .x_in (sops[RW].yaw_c),
    .angle(yaw_a)
  );

  always_comb begin
    p_res.roll    = signed'(roll_a);
    p_res.yaw     = signed'(yaw_a);
    p_res.clamped = pf[AT_LAT-1].clamp;
    if (pf[AT_LAT-1].clamp) begin
      p_res.pitch = pf[AT_LAT-1].neg ? PITCH_NEG : PITCH_POS;
    end else begin
      p_res.pitch = signed'(pitch_a);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
      sb_valid <= 1'b0;
    end else if (!ob_valid || euler.ready) begin
      if (sb_valid) begin
        ob       <= sb;
        ob_valid <= 1'b1;
        sb_valid <= 1'b0;
      end else begin
        ob       <= p_res;
        ob_valid <= vld[VLAT-1];
      end
    end else if (en && vld[VLAT-1]) begin
      sb       <= p_res;
      sb_valid <= 1'b1;
    end
  end

  assign euler.valid         = ob_valid;
  assign euler.roll_angle    = ob.roll;
  assign euler.pitch_angle   = ob.pitch;
  assign euler.yaw_angle     = ob.yaw;
  assign euler.pitch_clamped = ob.clamped;

  `QTE_ASSERT_NOW(a_skid_behind_out, clk, rst, sb_valid, ob_valid)
  `QTE_ASSERT_NEXT(a_skid_holds, clk, rst, sb_valid && !euler.ready, sb_valid)
  `QTE_ASSERT_NOW(a_clamp_pitch, clk, rst, ob_valid && ob.clamped, ob.pitch == PITCH_POS || ob.pitch == PITCH_NEG)

endmodule

### verif/qte_euler_checker.sv
`timescale 1ns / 100ps
// Checker for the quaternion to Euler angle converter: predicts each result from the
// accepted quaternions and compares it with the result channel. Depends on qte_pkg
// and the two channel interfaces.
module qte_euler_checker import qte_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int DATA_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  qte_quat_if         quat,
  qte_euler_if        euler,
  output int          mismatches,
  output int          pending
);

  result_t angles_due[$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Vectoring CORDIC angle in 16-bit binary angle units.
  function automatic logic [ANG_W-1:0] cordic_angle(longint sy, longint sx);
    longint m;
    longint hi;
    longint xs;
    longint ys;
    logic [31:0] acc;
    int d;
    longint t;
    m = (magnitude(sx) > magnitude(sy)) ? magnitude(sx) : magnitude(sy);
    hi = longint'(1) << (DATA_BITS - 2);
    acc = '0;
    if (m == 0) return '0;
    d = 0;
    if (m >= hi) begin
      while ((m >> d) >= hi) d++;
      sx = floor_shift(sx, d);
      sy = floor_shift(sy, d);
    end else begin
      while ((m << d) < (hi >> 1)) d++;
      sx = sx << d;
      sy = sy << d;
    end
    if (sx < 0) begin
      t = sx;
      if (sy >= 0) begin
        sx = sy;
        sy = -t;
        acc = QUARTER_POS;
      end else begin
        sx = -sy;
        sy = t;
        acc = QUARTER_NEG;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < ANG_TABLE_LEN; i++) begin
      xs = floor_shift(sx, i);
      ys = floor_shift(sy, i);
      if (sy >= 0) begin
        sx = sx + ys;
        sy = sy - xs;
        acc = acc + ATAN_TURNS[i];
      end else begin
        sx = sx - ys;
        sy = sy + xs;
        acc = acc - ATAN_TURNS[i];
      end
    end
    acc = acc + ROUND_HALF;
    return acc[31:16];
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic result_t euler_of(longint w, longint x, longint y, longint z);
    result_t r;
    longint ps;
    longint one;
    one = longint'(1) << 28;
    ps = 2 * (w * y - z * x);
    r.roll = cordic_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y));
    r.yaw = cordic_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z));
    if (magnitude(ps) >= one) begin
      r.pitch = (ps > 0) ? PITCH_POS : PITCH_NEG;
      r.clamped = 1'b1;
    end else begin
      r.pitch = cordic_angle(ps, floor_sqrt((longint'(1) << 56) - ps * ps));
      r.clamped = 1'b0;
    end
    return r;
  endfunction

  assign pending = angles_due.size();

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      mismatches <= 0;
    end else begin
      if (euler.valid && euler.ready) begin
        if (angles_due.size() == 0) begin
          if (mismatches < 10) $display("unexpected result at %0t", $realtime);
          mismatches <= mismatches + 1;
        end else begin
          want = angles_due.pop_front();
          if (euler.roll_angle !== want.roll || euler.pitch_angle !== want.pitch ||
              euler.yaw_angle !== want.yaw || euler.pitch_clamped !== want.clamped) begin
            if (mismatches < 10)
              $display("mismatch: expected roll %0d pitch %0d yaw %0d clamp %0b, got %0d %0d %0d %0b",
                       want.roll, want.pitch, want.yaw, want.clamped, euler.roll_angle,
                       euler.pitch_angle, euler.yaw_angle, euler.pitch_clamped);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (quat.valid && quat.ready)
        angles_due.push_back(euler_of(quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z));
    end
  end

endmodule

### verif/quaternion_to_euler_angles_tb.sv
`timescale 1ns / 100ps
// Top of the converter testbench: clock, reset, quaternion stimulus and result stalls.
// Depends on qte_pkg, the channel interfaces, the converter and qte_euler_checker.
module quaternion_to_euler_angles_tb import qte_pkg::*;;

  localparam int WATCHDOG_CYCLES = 3000;

  logic clk;
  logic rst;
  logic calm;
  logic quat_ready_seen;
  logic euler_ready_seen;
  logic euler_valid_seen;
  int   mismatches;
  int   pending;
  int   quiet_cycles;

  qte_quat_if  quat();
  qte_euler_if euler();

  quaternion_to_euler_angles dut (.clk(clk), .rst(rst), .quat(quat), .euler(euler));
  qte_euler_checker checker_i (.clk(clk), .rst(rst), .quat(quat), .euler(euler),
                               .mismatches(mismatches), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Handshake inputs only change at rising edges, so the falling edge sees settled values.
  always @(negedge clk) begin
    quat_ready_seen = quat.ready;
    euler_ready_seen = euler.ready;
    euler_valid_seen = euler.valid;
  end

  always @(posedge clk) begin
    if (rst || (quat.valid && quat_ready_seen) || (euler_valid_seen && euler_ready_seen))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side stalls in bursts until the calm tail of the run.
  initial begin
    euler.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        euler.ready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(posedge clk);
      end else begin
        euler.ready <= 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(posedge clk);
      end
    end
  end

  task automatic send_quat(logic [Q_W-1:0] w, logic [Q_W-1:0] x,
                           logic [Q_W-1:0] y, logic [Q_W-1:0] z);
    if (!calm && $urandom_range(0, 5) == 0) begin
      quat.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    quat.valid <= 1'b1;
    quat.quat_w <= w;
    quat.quat_x <= x;
    quat.quat_y <= y;
    quat.quat_z <= z;
    do @(posedge clk); while (!quat_ready_seen);
  endtask

  function automatic logic [Q_W-1:0] near(int v);
    int r;
    r = v + $signed($urandom_range(0, 64)) - 32;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[Q_W-1:0];
  endfunction

  initial begin
    int a;
    int b;
    calm = 1'b0;
    quiet_cycles = 0;
    rst <= 1'b1;
    quat.valid <= 1'b0;
    quat.quat_w <= '0;
    quat.quat_x <= '0;
    quat.quat_y <= '0;
    quat.quat_z <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests: zero and identity, the half turn, clamp edges, field extremes.
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(0, 0, 16384, 0);
    send_quat(16384, 0, 8192, 0);
    send_quat(16384, 0, -8192, 0);
    send_quat(16384, 0, 8191, 0);
    send_quat(-16384, 0, 8191, 0);
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 11585, 11585, -11585);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_quat(1, 1, 1, 1);
    send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_quat(0, 0, 0, 1);

    for (int n = 0; n < 800; n++) begin
      if (n == 700) calm = 1'b1;
      case ($urandom_range(0, 4))
        0: send_quat($urandom, $urandom, $urandom, $urandom);
        1, 2: send_quat($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                        $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
        default: begin
          // Near gimbal lock: w close to +-y and x close to -+z.
          a = $urandom_range(0, 23170) - 11585;
          b = $urandom_range(0, 23170) - 11585;
          if ($urandom_range(0, 1)) send_quat(near(a), near(b), near(a), near(-b));
          else send_quat(near(a), near(b), near(-a), near(b));
        end
      endcase
    end
    quat.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
